FILE: rtl/stiru_pkg.sv
// ----------------------------------------------------------------------------
// stiru_pkg
// shared sizes, codes and entry type of the sorted table insert/remove unit
// ----------------------------------------------------------------------------
package stiru_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 16;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int XW       = (CW > 4) ? CW : 4;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    // one stored entry
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] id;
    } t_entry;

endpackage

FILE: rtl/sorted_table_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_unit
// price-sorted table of (price, id) entries with insert, remove by id, read
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_ready carries one command beat (insert,
//   remove by id, read at position); output channel o_out_valid / i_out_ready
//   returns exactly one result beat per command, with the count after it.
//   the table lives in one single-port-write, registered-read memory; insert
//   and remove walk it one entry at a time through a read-then-act step.
//   an insert shifts each entry above its slot up by one; when the slot is
//   above zero one extra read finds the stop entry. remove walks the whole
//   table, read does a single read, and full insert, remove on an empty
//   table, bad position and unused code go straight to the result.
//   one command is in flight at a time; the next beat is taken as soon as
//   the previous result sits in the output register, even if not yet taken,
//   so no new command is taken before the last one is done.
//   reset clears the count and both handshakes; memory contents are not
//   cleared, entries at or above the count are never read.
//   a stalled receiver holds the result in the output register; a finished
//   command then waits before its result is loaded, and no new beat is taken.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_unit
    import stiru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_price_key,
    input  logic signed [31:0] i_item_id,
    input  logic [3:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_entry_price,
    output logic signed [31:0] o_entry_id,
    output logic [4:0]         o_entry_count
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_REM_RD  = 4'd4;
    localparam logic [3:0] S_REM_CHK = 4'd5;
    localparam logic [3:0] S_RD_RD   = 4'd6;
    localparam logic [3:0] S_RD_DATA = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    // table memory
    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    // control and working registers
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [1:0]    r_cmd;
    logic [31:0]   r_key;
    logic [31:0]   r_id;
    logic [1:0]    r_res_status, n_res_status;
    logic [31:0]   r_res_price, n_res_price;
    logic [31:0]   r_res_id, n_res_id;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_price;
    logic [31:0]   r_o_id;
    logic [4:0]    r_o_count;

    // memory port controls
    logic          w_rd_en;
    logic [CW-1:0] w_rd_idx;
    logic          w_we;
    logic [CW-1:0] w_wr_idx;
    t_entry        w_wr_data;

    logic          w_accept;
    logic          w_out_free;
    logic [XW-1:0] w_pos_x;
    logic [XW-1:0] w_count_x;
    logic          w_ge;
    logic          w_match;
    logic          w_last;
    t_entry        w_new;

    assign o_in_ready    = (r_state == S_IDLE);
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_pos_x       = XW'(i_position);
    assign w_count_x     = XW'(r_count);
    assign w_ge          = $signed(r_rd_data.price) >= $signed(r_key);
    assign w_match       = (r_rd_data.id == r_id);
    assign w_last        = (r_idx == (r_count - 1'b1));
    assign w_new.price   = r_key;
    assign w_new.id      = r_id;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_entry_price = r_o_price;
    assign o_entry_id    = r_o_id;
    assign o_entry_count = r_o_count;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx[AW-1:0]] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_idx[AW-1:0]];
        end
    end

    // sequencer next state and memory accesses
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_price  = r_res_price;
        n_res_id     = r_res_id;
        w_rd_en      = 1'b0;
        w_rd_idx     = r_idx;
        w_we         = 1'b0;
        w_wr_idx     = r_idx;
        w_wr_data    = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_status = ST_OK;
                    n_res_price  = '0;
                    n_res_id     = '0;
                    n_found      = 1'b0;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = S_INS_PUT;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_NOT_FOUND;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = '0;
                                n_state = S_REM_RD;
                            end
                        end
                        CMD_READ: begin
                            if (w_pos_x >= w_count_x) begin
                                n_res_status = ST_BAD_POS;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = w_pos_x[CW-1:0];
                                n_state = S_RD_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // insert: read the entry just below the gap
            S_INS_RD: begin
                w_rd_en  = 1'b1;
                w_rd_idx = r_idx - 1'b1;
                n_state  = S_INS_WR;
            end
            // insert: shift it up, or stop and drop the new entry in the gap
            S_INS_WR: begin
                if (w_ge) begin
                    w_we     = 1'b1;
                    w_wr_idx = r_idx;
                    n_idx    = r_idx - 1'b1;
                    n_state  = (r_idx == CW'(1)) ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                w_we      = 1'b1;
                w_wr_idx  = r_idx;
                w_wr_data = w_new;
                n_count   = r_count + 1'b1;
                n_state   = S_DONE;
            end
            // remove: walk upward, close the hole once the id is found
            S_REM_RD: begin
                w_rd_en = 1'b1;
                n_state = S_REM_CHK;
            end
            S_REM_CHK: begin
                if (r_found) begin
                    w_we     = 1'b1;
                    w_wr_idx = r_idx - 1'b1;
                end else if (w_match) begin
                    n_found     = 1'b1;
                    n_res_price = r_rd_data.price;
                    n_res_id    = r_rd_data.id;
                end
                if (w_last) begin
                    if (r_found || w_match) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_REM_RD;
                end
            end
            // read at position
            S_RD_RD: begin
                w_rd_en = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_res_price = r_rd_data.price;
                n_res_id    = r_rd_data.id;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_price  <= n_res_price;
        r_res_id     <= n_res_id;
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= i_price_key;
            r_id  <= i_item_id;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_price  <= r_res_price;
            r_o_id     <= r_res_id;
            r_o_count  <= 5'(r_count);
        end
    end

`ifndef ASSERT_OFF
    // count never runs past the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a full-table result only comes from a full table
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

    // an insert that went in leaves a non-empty table
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_PUT) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    // not-found and bad-position beats carry zero payload
    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_res_status == ST_NOT_FOUND ||
            r_res_status == ST_BAD_POS)) |-> (r_res_price == '0 && r_res_id == '0))
        else $error("miss result carries an entry");

    // memory writes only happen while a command modifies the table
    a_write_in_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_cmd == CMD_INSERT || r_cmd == CMD_REMOVE))
        else $error("table written outside insert or remove");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted price table insert/remove/read unit
// ----------------------------------------------------------------------------
// a queue of pending commands feeds a falling-edge driver; a rising-edge
// monitor runs every accepted command through a local copy of the table
// and checks each result beat, in order, against the oldest expected one.
// a short directed run covers empty, extreme, tie and duplicate-id cases,
// then biased random fill/drain runs push the table between empty and full
// under four idle/stall mixes on the two channels.
// ----------------------------------------------------------------------------
module tb
    import stiru_pkg::*;
;

    localparam logic [1:0]         CMD_SPARE    = 2'd3;
    localparam logic signed [31:0] WORD_MIN     = 32'sh80000000;
    localparam logic signed [31:0] WORD_MAX     = 32'sh7FFFFFFF;
    localparam int                 RANDOM_ITEMS = 360;
    localparam int                 CYCLE_LIMIT  = 500000;
    localparam int                 TAIL_CYCLES  = 80;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] price;
        logic signed [31:0] id;
        logic [3:0]         pos;
    } t_table_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] price;
        logic signed [31:0] id;
        logic [4:0]         count;
    } t_table_result;

    // dut ports
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_cmd         = CMD_SPARE;
    logic signed [31:0] i_price_key   = '0;
    logic signed [31:0] i_item_id     = '0;
    logic [3:0]         i_position    = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_entry_price;
    logic signed [31:0] o_entry_id;
    logic [4:0]         o_entry_count;

    // stimulus and scoreboard state
    t_table_cmd         cmd_pending[$];
    t_table_result      expected_results[$];
    logic signed [31:0] shadow_ids[$];
    logic               in_beat_q      = 1'b0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 fail_count     = 0;
    int                 cycle_count    = 0;
    bit                 filling        = 1'b1;
    int                 mode_left      = 20;
    t_table_cmd         drive_item;
    t_table_cmd         seen_cmd;
    t_table_result      want;

    // local copy of the table
    logic signed [31:0] price_book[CAPACITY];
    logic signed [31:0] id_book[CAPACITY];
    int                 book_fill      = 0;

    // coverage tallies
    int                 cmd_tally[4]   = '{0, 0, 0, 0};
    int                 full_rejects   = 0;
    int                 id_misses      = 0;
    int                 bad_reads      = 0;
    int                 removes_done   = 0;
    int                 max_fill_seen  = 0;

    sorted_table_insert_remove_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_price_key   (i_price_key),
        .i_item_id     (i_item_id),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_price (o_entry_price),
        .o_entry_id    (o_entry_id),
        .o_entry_count (o_entry_count)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // apply one command to the local table and return its result beat
    function automatic t_table_result table_apply(input t_table_cmd c);
        t_table_result      r;
        int                 slot;
        int                 hit;
        int                 i;
        logic signed [31:0] key;
        r     = '0;
        key   = c.price;
        cmd_tally[c.cmd]++;
        case (c.cmd)
            CMD_INSERT: begin
                if (book_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_rejects++;
                end else begin
                    // new entry goes ahead of the first price >= key
                    slot = book_fill;
                    for (i = 0; i < book_fill; i++) begin
                        if ($signed(price_book[i]) >= $signed(key)) begin
                            slot = i;
                            break;
                        end
                    end
                    for (i = book_fill; i > slot; i--) begin
                        price_book[i] = price_book[i - 1];
                        id_book[i]    = id_book[i - 1];
                    end
                    price_book[slot] = key;
                    id_book[slot]    = c.id;
                    book_fill++;
                end
            end
            CMD_REMOVE: begin
                hit = book_fill;
                for (i = 0; i < book_fill; i++) begin
                    if (id_book[i] == c.id) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= book_fill) begin
                    r.status = ST_NOT_FOUND;
                    id_misses++;
                end else begin
                    r.price = price_book[hit];
                    r.id    = id_book[hit];
                    for (i = hit; i + 1 < book_fill; i++) begin
                        price_book[i] = price_book[i + 1];
                        id_book[i]    = id_book[i + 1];
                    end
                    book_fill--;
                    removes_done++;
                end
            end
            CMD_READ: begin
                if (int'(c.pos) >= book_fill) begin
                    r.status = ST_BAD_POS;
                    bad_reads++;
                end else begin
                    r.price = price_book[c.pos];
                    r.id    = id_book[c.pos];
                end
            end
            default: begin
                // spare code leaves the table alone
            end
        endcase
        if (book_fill > max_fill_seen) max_fill_seen = book_fill;
        r.count = book_fill[4:0];
        return r;
    endfunction

    // queue one command and track which ids the table will hold
    task automatic queue_cmd(input logic [1:0] cmd, input logic signed [31:0] price,
                             input logic signed [31:0] id, input logic [3:0] pos);
        t_table_cmd c;
        int         k;
        c.cmd   = cmd;
        c.price = price;
        c.id    = id;
        c.pos   = pos;
        cmd_pending.push_back(c);
        if (cmd == CMD_INSERT && shadow_ids.size() < CAPACITY) begin
            shadow_ids.push_back(id);
        end else if (cmd == CMD_REMOVE) begin
            for (k = 0; k < shadow_ids.size(); k++) begin
                if (shadow_ids[k] == id) begin
                    shadow_ids.delete(k);
                    break;
                end
            end
        end
    endtask

    // half small values for ties and repeats, the rest full range and extremes
    function automatic logic signed [31:0] rand_word(input int span);
        int r;
        r = $urandom_range(99);
        if (r < 50) return int'($urandom_range(2 * span)) - span;
        if (r < 80) return $urandom;
        case ($urandom_range(3))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // biased fill/drain runs so the count swings between empty and full
    task automatic queue_random();
        int                 r;
        int                 fill;
        logic [1:0]         cmd;
        logic signed [31:0] id;
        logic [3:0]         pos;
        fill = shadow_ids.size();
        if (mode_left == 0) begin
            filling   = !filling;
            mode_left = $urandom_range(15, 50);
        end
        mode_left--;
        r = $urandom_range(99);
        if (r < 5)                     cmd = CMD_SPARE;
        else if (r < 25)               cmd = CMD_READ;
        else if ((r < 80) == filling)  cmd = CMD_INSERT;
        else                           cmd = CMD_REMOVE;
        if (cmd == CMD_REMOVE && fill > 0 && $urandom_range(9) < 8)
            id = shadow_ids[$urandom_range(fill - 1)];
        else
            id = rand_word(3);
        if (fill > 0 && $urandom_range(9) < 7)
            pos = 4'($urandom_range(fill - 1));
        else
            pos = 4'($urandom_range(15));
        queue_cmd(cmd, rand_word(8), id, pos);
    endtask

    // compare one field of a result beat
    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // driver: new beat or idle after acceptance, random receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_beat_q) begin
                if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_item   = cmd_pending.pop_front();
                    i_in_valid  <= 1'b1;
                    i_cmd       <= drive_item.cmd;
                    i_price_key <= drive_item.price;
                    i_item_id   <= drive_item.id;
                    i_position  <= drive_item.pos;
                end else begin
                    i_in_valid  <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                seen_cmd.cmd   = i_cmd;
                seen_cmd.price = i_price_key;
                seen_cmd.id    = i_item_id;
                seen_cmd.pos   = i_position;
                expected_results.push_back(table_apply(seen_cmd));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("entry_price", want.price, o_entry_price);
                    check_field("entry_id", want.id, o_entry_id);
                    check_field("entry_count", 32'(want.count), 32'(o_entry_count));
                end
            end
        end
        in_beat_q <= i_rst_n && i_in_valid && o_in_ready;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // sequence: reset, then four idle/stall mixes, the first opening with a directed run
    initial begin
        int send_mix[4];
        int recv_mix[4];
        int ph;
        int n;
        send_mix = '{0, 74, 0, 23};
        recv_mix = '{0, 0, 74, 23};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            if (ph == 0) begin
                // empty table: bad read, missed remove, spare code
                queue_cmd(CMD_READ,   '0, '0, 4'd0);
                queue_cmd(CMD_REMOVE, '0, 32'sd5, 4'd0);
                queue_cmd(CMD_SPARE,  '0, '0, 4'd0);
                // extremes, ties and a repeated id
                queue_cmd(CMD_INSERT, '0, 32'sd1, 4'd0);
                queue_cmd(CMD_INSERT, WORD_MAX, WORD_MAX, 4'd0);
                queue_cmd(CMD_INSERT, WORD_MIN, WORD_MIN, 4'd0);
                queue_cmd(CMD_INSERT, '0, 32'sd2, 4'd0);
                queue_cmd(CMD_INSERT, '1, '1, 4'd0);
                queue_cmd(CMD_INSERT, '0, 32'sd1, 4'd0);
                queue_cmd(CMD_READ,   '0, '0, 4'd0);
                queue_cmd(CMD_READ,   '0, '0, 4'd2);
                queue_cmd(CMD_READ,   '0, '0, 4'd3);
                queue_cmd(CMD_READ,   '0, '0, 4'd5);
                queue_cmd(CMD_READ,   '0, '0, 4'd6);
                queue_cmd(CMD_READ,   '1, '1, 4'd15);
                // lowest-position match goes first, then a miss
                queue_cmd(CMD_REMOVE, '0, 32'sd1, 4'd0);
                queue_cmd(CMD_REMOVE, '0, 32'sd1, 4'd0);
                queue_cmd(CMD_REMOVE, '0, 32'sd1, 4'd0);
                queue_cmd(CMD_SPARE,  '1, '1, 4'd15);
                queue_cmd(CMD_REMOVE, '0, WORD_MIN, 4'd0);
                queue_cmd(CMD_READ,   '0, '0, 4'd0);
                queue_cmd(CMD_INSERT, 32'sd1, '0, 4'd0);
                queue_cmd(CMD_READ,   '0, '0, 4'd1);
            end
            for (n = 0; n < RANDOM_ITEMS; n++) queue_random();
            // drain before the next mix
            while (cmd_pending.size() > 0 || i_in_valid || expected_results.size() > 0)
                @(negedge i_clk);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        $display("covered %0d inserts, %0d removes, %0d reads, %0d spare codes",
                 cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
        $display("with %0d full rejects, %0d id misses, %0d bad reads, peak fill %0d",
                 full_rejects, id_misses, bad_reads, max_fill_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
